@@ rtl/orcd_pkg.sv @@
// ---------------------------------------------------------------------------
// orcd_pkg: shared types and constants of the capture ring
// Sample layout, command codes and register decode used by the front end,
// the command queue and the drain engine.
// ---------------------------------------------------------------------------
package orcd_pkg;

  // Item kind carried on func_i.
  typedef enum logic {
    FUNC_SAMPLE = 1'b0,
    FUNC_TICK   = 1'b1
  } func_e;

  // Work handed from the front end to the drain engine.
  typedef enum logic {
    CMD_STORE = 1'b0,
    CMD_DRAIN = 1'b1
  } cmd_op_e;

  typedef struct packed {
    logic [31:0] time_ms;
    logic [15:0] v_raw;
    logic [15:0] i_raw;
    logic [31:0] v_filt;
    logic [31:0] i_filt;
    logic [31:0] power_bits;
    logic [15:0] ask_pointer;
    logic [7:0]  ask_flag;
  } sample_t;

  localparam int unsigned SAMPLE_W = $bits(sample_t);

  typedef struct packed {
    cmd_op_e op;
    sample_t sample;
  } cmd_t;

  // Configuration port: one 32-bit register per word.
  localparam int unsigned ADDR_W = 3;
  localparam int unsigned DATA_W = 32;
  localparam logic [0:0] REG_CAPTURE_ENABLE = 1'b0;

endpackage

@@ rtl/orcd_front.sv @@
// ---------------------------------------------------------------------------
// orcd_front: item intake, tick prescaler and configuration register
// Accepts items, turns them into store or drain commands for the back end,
// and drops items that have no effect on the ring.
// ---------------------------------------------------------------------------
module orcd_front import orcd_pkg::*; #(
  parameter int unsigned TICK_DIVIDE = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // Configuration port.
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  // Item intake.
  input  logic              start,
  output logic              busy,
  input  func_e             func_i,
  input  sample_t           sample_i,
  // Command queue push side.
  input  logic              q_full_i,
  output logic              q_push_o,
  output cmd_t              q_cmd_o
);

  localparam int unsigned PS_W = (TICK_DIVIDE > 1) ? $clog2(TICK_DIVIDE) : 1;

  logic            enable_q, enable_d;
  logic [PS_W-1:0] ps_q, ps_d;
  logic            accept;
  logic            ps_wrap;
  logic            cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    enable_d = enable_q;
    if (cfg_wr && (paddr[ADDR_W-1:2] == REG_CAPTURE_ENABLE)) begin
      enable_d = pwdata[0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[ADDR_W-1:2] == REG_CAPTURE_ENABLE) begin
      prdata[0] = enable_q;
    end
  end

  assign busy    = q_full_i;
  assign accept  = start && !busy;
  assign ps_wrap = (ps_q == PS_W'(TICK_DIVIDE - 1));

  always_comb begin
    ps_d = ps_q;
    if (accept && (func_i == FUNC_TICK)) begin
      ps_d = ps_wrap ? '0 : ps_q + PS_W'(1);
    end
  end

  always_comb begin
    q_push_o       = 1'b0;
    q_cmd_o.op     = CMD_STORE;
    q_cmd_o.sample = sample_i;
    if (accept && enable_q) begin
      if (func_i == FUNC_SAMPLE) begin
        q_push_o = 1'b1;
      end else if (ps_wrap) begin
        q_push_o   = 1'b1;
        q_cmd_o.op = CMD_DRAIN;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= 1'b0;
      ps_q     <= '0;
    end else begin
      enable_q <= enable_d;
      ps_q     <= ps_d;
    end
  end

endmodule

@@ rtl/orcd_cmd_queue.sv @@
// ---------------------------------------------------------------------------
// orcd_cmd_queue: two-entry command queue
// Decouples item intake from the ring store so that each side stalls alone.
// ---------------------------------------------------------------------------
module orcd_cmd_queue import orcd_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  input  logic pop_i,
  output logic empty_o,
  output cmd_t cmd_o
);

  cmd_t       entry_q [2];
  logic       wr_q, wr_d;
  logic       rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == 2'd2);
  assign empty_o = (cnt_q == 2'd0);
  assign cmd_o   = entry_q[rd_q];

  always_comb begin
    wr_d  = push_i ? ~wr_q : wr_q;
    rd_d  = pop_i ? ~rd_q : rd_q;
    cnt_d = cnt_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  a_no_push_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o || pop_i)
    else $error("command pushed into a full queue");

  a_no_pop_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("command popped from an empty queue");

endmodule

@@ rtl/orcd_back.sv @@
// ---------------------------------------------------------------------------
// orcd_back: ring store and drain engine
// Writes samples into the single-port ring, overwriting the oldest entry
// when full, and reads out drain batches one entry per cycle.
// ---------------------------------------------------------------------------
module orcd_back import orcd_pkg::*; #(
  parameter int unsigned DEPTH     = 512,
  parameter int unsigned BATCH_MAX = 16
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    q_empty_i,
  input  cmd_t    q_cmd_i,
  output logic    q_pop_o,
  output logic    res_valid_o,
  output logic    res_last_o,
  output sample_t res_sample_o
);

  localparam int unsigned PTR_W  = $clog2(DEPTH);
  localparam int unsigned FILL_W = $clog2(DEPTH + 1);
  localparam int unsigned BCNT_W = $clog2(BATCH_MAX) + 1;

  localparam logic ST_IDLE  = 1'b0;
  localparam logic ST_DRAIN = 1'b1;

  logic [SAMPLE_W-1:0] mem [DEPTH];
  logic [SAMPLE_W-1:0] rdata_q;

  logic              state_q, state_d;
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic [BCNT_W-1:0] bcnt_q, bcnt_d;
  logic              rd_valid_q, rd_last_q;
  logic              we, re, last;
  logic              fill_full;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    ptr_next = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  assign fill_full = (fill_q == FILL_W'(DEPTH));
  assign q_pop_o   = (state_q == ST_IDLE) && !q_empty_i;
  assign we        = q_pop_o && (q_cmd_i.op == CMD_STORE);
  assign re        = (state_q == ST_DRAIN);
  assign last      = (bcnt_q == BCNT_W'(BATCH_MAX - 1)) || (fill_q == FILL_W'(1));

  always_comb begin
    state_d  = state_q;
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    fill_d   = fill_q;
    bcnt_d   = bcnt_q;
    case (state_q)
      ST_IDLE: begin
        if (we) begin
          wr_ptr_d = ptr_next(wr_ptr_q);
          if (fill_full) begin
            rd_ptr_d = ptr_next(rd_ptr_q);
          end else begin
            fill_d = fill_q + FILL_W'(1);
          end
        end else if (q_pop_o && (fill_q != '0)) begin
          // Drain on an empty ring ends at once without results.
          state_d = ST_DRAIN;
          bcnt_d  = '0;
        end
      end
      ST_DRAIN: begin
        rd_ptr_d = ptr_next(rd_ptr_q);
        fill_d   = fill_q - FILL_W'(1);
        bcnt_d   = bcnt_q + BCNT_W'(1);
        if (last) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Single-port store: a write and a read never fall in the same cycle.
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[wr_ptr_q] <= q_cmd_i.sample;
    end else if (re) begin
      rdata_q <= mem[rd_ptr_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      wr_ptr_q   <= '0;
      rd_ptr_q   <= '0;
      fill_q     <= '0;
      bcnt_q     <= '0;
      rd_valid_q <= 1'b0;
      rd_last_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      wr_ptr_q   <= wr_ptr_d;
      rd_ptr_q   <= rd_ptr_d;
      fill_q     <= fill_d;
      bcnt_q     <= bcnt_d;
      rd_valid_q <= re;
      rd_last_q  <= re && last;
    end
  end

  assign res_valid_o  = rd_valid_q;
  assign res_last_o   = rd_last_q;
  assign res_sample_o = sample_t'(rdata_q);

  a_fill_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_W'(DEPTH))
    else $error("fill count beyond ring depth");

  a_read_only_filled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    re |-> fill_q != '0)
    else $error("drain read from an empty ring");

  a_batch_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    re |-> bcnt_q < BCNT_W'(BATCH_MAX))
    else $error("drain batch longer than the batch limit");

endmodule

@@ rtl/overwrite_ring_capture_drain_top.sv @@
// ---------------------------------------------------------------------------
// overwrite_ring_capture_drain_top: telemetry capture ring with batch drain
// While enabled, stores samples in an overwrite-oldest ring and, on every
// TICK_DIVIDE-th tick, emits up to BATCH_MAX oldest entries, marking the last one.
// ---------------------------------------------------------------------------
// Drain path: a drain command goes through the command queue into the drain
// engine, which reads one beat per cycle from the single-port ring into a register.
// Throughput: one item per cycle while the two-entry command queue has room; a
// drain holds the ring until its last beat is read, and busy rises when the
// queue fills behind it. The receiver cannot stall.
// Reset: asynchronous, active low; clears all control state, not the ring contents.
module overwrite_ring_capture_drain_top import orcd_pkg::*; #(
  parameter int unsigned DEPTH       = 512,
  parameter int unsigned BATCH_MAX   = 16,
  parameter int unsigned TICK_DIVIDE = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // Configuration port (APB style, always ready).
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  // Command side: an item is taken when start is high and busy is low.
  input  logic              start,
  output logic              busy,
  input  logic              func_i,
  input  logic [31:0]       time_ms_i,
  input  logic [15:0]       v_raw_i,
  input  logic [15:0]       i_raw_i,
  input  logic [31:0]       v_filt_i,
  input  logic [31:0]       i_filt_i,
  input  logic [31:0]       power_bits_i,
  input  logic [15:0]       ask_pointer_i,
  input  logic [7:0]        ask_flag_i,
  // Result side: one beat per cycle in which result_valid_o is high.
  output logic              result_valid_o,
  output logic [31:0]       out_time_ms_o,
  output logic [15:0]       out_v_raw_o,
  output logic [15:0]       out_i_raw_o,
  output logic [31:0]       out_v_filt_o,
  output logic [31:0]       out_i_filt_o,
  output logic [31:0]       out_power_o,
  output logic [15:0]       out_ask_pointer_o,
  output logic [7:0]        out_ask_flag_o,
  output logic              last_o
);

  // Incoming sample fields gathered into one word for the queue and ring.
  sample_t in_sample;
  sample_t res_sample;

  // Front end to queue, and queue to drain engine.
  cmd_t push_cmd;
  cmd_t head_cmd;
  logic q_push, q_full, q_pop, q_empty;

  assign in_sample.time_ms     = time_ms_i;
  assign in_sample.v_raw       = v_raw_i;
  assign in_sample.i_raw       = i_raw_i;
  assign in_sample.v_filt      = v_filt_i;
  assign in_sample.i_filt      = i_filt_i;
  assign in_sample.power_bits  = power_bits_i;
  assign in_sample.ask_pointer = ask_pointer_i;
  assign in_sample.ask_flag    = ask_flag_i;

  // The front end owns the enable register and the tick prescaler. It only
  // forwards enabled samples as stores and enabled firing ticks as drains;
  // disabled items and non-firing ticks end here.
  orcd_front #(
    .TICK_DIVIDE (TICK_DIVIDE)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .start    (start),
    .busy     (busy),
    .func_i   (func_e'(func_i)),
    .sample_i (in_sample),
    .q_full_i (q_full),
    .q_push_o (q_push),
    .q_cmd_o  (push_cmd)
  );

  // Short queue so intake keeps going while a drain batch is read out.
  orcd_cmd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (push_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .cmd_o   (head_cmd)
  );

  // The back end holds the ring and executes one command at a time, in
  // the order the items were accepted.
  orcd_back #(
    .DEPTH     (DEPTH),
    .BATCH_MAX (BATCH_MAX)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .q_empty_i    (q_empty),
    .q_cmd_i      (head_cmd),
    .q_pop_o      (q_pop),
    .res_valid_o  (result_valid_o),
    .res_last_o   (last_o),
    .res_sample_o (res_sample)
  );

  assign out_time_ms_o     = res_sample.time_ms;
  assign out_v_raw_o       = res_sample.v_raw;
  assign out_i_raw_o       = res_sample.i_raw;
  assign out_v_filt_o      = res_sample.v_filt;
  assign out_i_filt_o      = res_sample.i_filt;
  assign out_power_o       = res_sample.power_bits;
  assign out_ask_pointer_o = res_sample.ask_pointer;
  assign out_ask_flag_o    = res_sample.ask_flag;

endmodule
